@@ rtl/motor_command_frame_packer_macros.svh @@
// Assertion macros for the motor command frame packer.
`ifndef MOTOR_COMMAND_FRAME_PACKER_MACROS_SVH
`define MOTOR_COMMAND_FRAME_PACKER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MCFP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("mcfp check failed");
`define MCFP_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("mcfp reset check failed");
`else
`define MCFP_ASSERT(lbl, prop)
`define MCFP_ASSERT_RST(lbl, prop)
`endif
`endif

@@ rtl/mcfp_pkg.sv @@
// Shared constants and types for the motor command frame packer.
package mcfp_pkg;
  localparam int POSITION_BITS = 16;
  localparam int FIELD_BITS = 12;
  localparam int DIV_STAGES = (POSITION_BITS > FIELD_BITS) ? POSITION_BITS : FIELD_BITS;
  localparam int NUM_W = 32 + DIV_STAGES;
  localparam int NSTAGE = DIV_STAGES + 2;
  localparam int LANES = 5;
  localparam int LIMIT_W = 31;
  localparam int ADDR_W = 5;

  localparam logic [1:0] FUNC_CONTROL = 2'd0;
  localparam logic [1:0] FUNC_ENTER = 2'd1;
  localparam logic [1:0] FUNC_EXIT = 2'd2;
  localparam logic [1:0] FUNC_ZERO = 2'd3;

  localparam logic [63:0] FRAME_ENTER = 64'hFFFF_FFFF_FFFF_FFFC;
  localparam logic [63:0] FRAME_EXIT = 64'hFFFF_FFFF_FFFF_FFFD;
  localparam logic [63:0] FRAME_ZERO = 64'hFFFF_FFFF_FFFF_FFFE;

  localparam logic [2:0] REG_POSITION = 3'd0;
  localparam logic [2:0] REG_VELOCITY = 3'd1;
  localparam logic [2:0] REG_STIFFNESS = 3'd2;
  localparam logic [2:0] REG_DAMPING = 3'd3;
  localparam logic [2:0] REG_TORQUE = 3'd4;

  typedef struct packed {
    logic [LIMIT_W-1:0] position;
    logic [LIMIT_W-1:0] velocity;
    logic [LIMIT_W-1:0] stiffness;
    logic [LIMIT_W-1:0] damping;
    logic [LIMIT_W-1:0] torque;
  } limits_t;
endpackage

@@ rtl/mcfp_datapath.sv @@
// Clamp, offset and pipelined restoring division for the five set-points, then packing.
module mcfp_datapath (
  input  logic                   clk,
  input  logic                   en,
  input  mcfp_pkg::limits_t      limits,
  input  logic [1:0]             func,
  input  logic signed [31:0]     position_target,
  input  logic signed [31:0]     velocity_target,
  input  logic signed [31:0]     stiffness_gain,
  input  logic signed [31:0]     damping_gain,
  input  logic signed [31:0]     torque_feedforward,
  output logic [63:0]            frame
);
  import mcfp_pkg::*;

  logic [31:0]           x_in   [0:LANES-1];
  logic [LIMIT_W-1:0]    lim_in [0:LANES-1];

  logic [31:0]           rem  [0:DIV_STAGES][0:LANES-1];
  logic [31:0]           span [0:DIV_STAGES][0:LANES-1];
  logic [DIV_STAGES-1:0] low  [0:DIV_STAGES][0:LANES-1];
  logic [DIV_STAGES-1:0] quo  [0:DIV_STAGES][0:LANES-1];
  logic                  zr   [0:DIV_STAGES][0:LANES-1];
  logic [1:0]            fn   [0:DIV_STAGES];
  logic [15:0]           code [0:LANES-1];

  assign x_in[0] = position_target;
  assign x_in[1] = velocity_target;
  assign x_in[2] = stiffness_gain;
  assign x_in[3] = damping_gain;
  assign x_in[4] = torque_feedforward;
  assign lim_in[0] = limits.position;
  assign lim_in[1] = limits.velocity;
  assign lim_in[2] = limits.stiffness;
  assign lim_in[3] = limits.damping;
  assign lim_in[4] = limits.torque;

  always_ff @(posedge clk) begin
    if (en) begin
      fn[0] <= func;
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_fn
    always_ff @(posedge clk) begin
      if (en) begin
        fn[s+1] <= fn[s];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    localparam int W = (l == 0) ? POSITION_BITS : FIELD_BITS;
    localparam bit SYM = (l == 0) || (l == 1) || (l == 4);

    logic signed [33:0] xs, hi, lo, xc;
    logic [NUM_W-1:0]   num;
    logic [31:0]        off;

    always_comb begin
      xs = {{2{x_in[l][31]}}, x_in[l]};
      hi = {3'b000, lim_in[l]};
      lo = SYM ? -hi : 34'sd0;
      if (xs < lo) begin
        xc = lo;
      end else if (xs > hi) begin
        xc = hi;
      end else begin
        xc = xs;
      end
      off = 32'(xc - lo);
      num = (NUM_W'(off) << W) - NUM_W'(off);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        span[0][l] <= 32'(hi - lo);
        zr[0][l]   <= (hi <= lo);
        rem[0][l]  <= 32'(num >> W);
        low[0][l]  <= DIV_STAGES'(num[W-1:0]) << (DIV_STAGES - W);
        quo[0][l]  <= '0;
      end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
      logic [32:0] t;
      logic        ge;

      always_comb begin
        t  = {rem[k][l], low[k][l][DIV_STAGES-1]};
        ge = (t >= {1'b0, span[k][l]});
      end

      always_ff @(posedge clk) begin
        if (en) begin
          span[k+1][l] <= span[k][l];
          zr[k+1][l]   <= zr[k][l];
          if (k < W) begin
            rem[k+1][l] <= ge ? 32'(t - {1'b0, span[k][l]}) : t[31:0];
            low[k+1][l] <= low[k][l] << 1;
            quo[k+1][l] <= {quo[k][l][DIV_STAGES-2:0], ge};
          end else begin
            rem[k+1][l] <= rem[k][l];
            low[k+1][l] <= low[k][l];
            quo[k+1][l] <= quo[k][l];
          end
        end
      end
    end

    assign code[l] = zr[DIV_STAGES][l] ? 16'd0 : 16'(quo[DIV_STAGES][l][W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (fn[DIV_STAGES])
        FUNC_CONTROL: frame <= {code[0], code[1][11:0], code[2][11:0],
                                code[3][11:0], code[4][11:0]};
        FUNC_ENTER:   frame <= FRAME_ENTER;
        FUNC_EXIT:    frame <= FRAME_EXIT;
        default:      frame <= FRAME_ZERO;
      endcase
    end
  end
endmodule

@@ rtl/motor_command_frame_packer.sv @@
// Top level of the motor command frame packer: register port, word handshake and valid pipeline.
// One word is accepted every cycle while cmd_stall is low; the one-bit-per-stage quotient
// pipeline sets the depth. The pipeline halts only while a finished frame word waits
// under stall. Synchronous reset clears all valid bits and loads the default limits.
// Limit registers are written through the register port; the user must write them only
// while the block is idle, since the block itself does not enforce it.
module motor_command_frame_packer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mcfp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        cmd_valid,
  output logic                        cmd_stall,
  input  logic [1:0]                  func,
  input  logic signed [31:0]          position_target,
  input  logic signed [31:0]          velocity_target,
  input  logic signed [31:0]          stiffness_gain,
  input  logic signed [31:0]          damping_gain,
  input  logic signed [31:0]          torque_feedforward,
  output logic                        frame_valid,
  input  logic                        frame_stall,
  output logic [63:0]                 frame
);
  import mcfp_pkg::*;
  `include "motor_command_frame_packer_macros.svh"

  limits_t           limits;
  logic [NSTAGE-1:0] valid;
  logic              en;
  logic [2:0]        idx;

  assign pready = 1'b1;
  assign idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.position  <= 31'd819200;
      limits.velocity  <= 31'd3276800;
      limits.stiffness <= 31'd32768000;
      limits.damping   <= 31'd327680;
      limits.torque    <= 31'd1179648;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_POSITION:  limits.position  <= pwdata[LIMIT_W-1:0];
        REG_VELOCITY:  limits.velocity  <= pwdata[LIMIT_W-1:0];
        REG_STIFFNESS: limits.stiffness <= pwdata[LIMIT_W-1:0];
        REG_DAMPING:   limits.damping   <= pwdata[LIMIT_W-1:0];
        REG_TORQUE:    limits.torque    <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_POSITION:  prdata = {1'b0, limits.position};
      REG_VELOCITY:  prdata = {1'b0, limits.velocity};
      REG_STIFFNESS: prdata = {1'b0, limits.stiffness};
      REG_DAMPING:   prdata = {1'b0, limits.damping};
      REG_TORQUE:    prdata = {1'b0, limits.torque};
      default:       prdata = 32'd0;
    endcase
  end

  assign en = !frame_valid || !frame_stall;
  assign cmd_stall = !en;
  assign frame_valid = valid[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[NSTAGE-2:0], cmd_valid};
    end
  end

  mcfp_datapath u_datapath (
    .clk                (clk),
    .en                 (en),
    .limits             (limits),
    .func               (func),
    .position_target    (position_target),
    .velocity_target    (velocity_target),
    .stiffness_gain     (stiffness_gain),
    .damping_gain       (damping_gain),
    .torque_feedforward (torque_feedforward),
    .frame              (frame)
  );

  `MCFP_ASSERT_RST(a_reset_empty, rst |=> (valid == '0))
  `MCFP_ASSERT(a_hold_valid, (!$past(en) && !$past(rst)) |-> $stable(valid))
  `MCFP_ASSERT(a_stall_holds, (frame_valid && frame_stall) |=> (frame_valid && $stable(frame)))
endmodule
